/* sv/lmsq31_pkg.sv */
// ----------------------------------------------------------------------------
// LMS adaptive FIR package
// Shared types and constants for the Q31 LMS adaptive FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsq31_pkg;

  localparam int unsigned DW     = 32;
  localparam int unsigned CFG_AW = 2;

  // Request kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_TAPS  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_MU    = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_SHIFT = 2'd2;

  // Configuration reset values
  localparam logic [5:0]        TAPS_RST  = 6'd32;
  localparam logic [DW-1:0]     MU_RST    = 32'h4000_0000;
  localparam logic [4:0]        SHIFT_RST = 5'd0;

  // Q31 limits
  localparam logic signed [DW-1:0] Q31_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] Q31_MIN = 32'sh8000_0000;

  // Operation carried by the multiply pipeline
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_FIR  = 2'd1,
    OP_UPD  = 2'd2,
    OP_MU   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [DW-1:0]    sample;
    logic signed [DW-1:0]    reference;
    logic [4:0]              tap_index;
    logic signed [DW-1:0]    tap_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0]    filter_out;
    logic signed [DW-1:0]    error_out;
    logic signed [DW-1:0]    tap_read;
    logic                    is_read;
  } out_item_t;

  // Controls from the sequencer to the arithmetic unit
  typedef struct packed {
    op_e  op_b;     // operation whose memory data is present this cycle
    op_e  op_c;     // operation whose product is registered this cycle
    logic last_b;   // stage B holds the newest tap: take the new sample
    logic acc_clr;  // clear the accumulator
    logic ye_ld;    // load output and error from the accumulator
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* sv/lmsq31_stream_if.sv */
// ----------------------------------------------------------------------------
// LMS stream interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmsq31_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* sv/lmsq31_ram.sv */
// ----------------------------------------------------------------------------
// LMS generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsq31_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 32,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/lmsq31_mac.sv */
// ----------------------------------------------------------------------------
// LMS multiply-accumulate unit
// Shared 32x32 multiplier with accumulator, output/error, alpha and
// saturating weight update.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsq31_mac import lmsq31_pkg::*; (
  input  logic                 clk_i,
  input  mac_ctrl_t            ctrl_i,
  input  logic signed [DW-1:0] hist_rdata_i,
  input  logic signed [DW-1:0] w_rdata_i,
  input  logic signed [DW-1:0] sample_i,
  input  logic signed [DW-1:0] reference_i,
  input  logic signed [DW-1:0] step_size_i,
  input  logic [4:0]           output_shift_i,
  output logic signed [DW-1:0] hist_wdata_o,
  output logic signed [DW-1:0] w_wdata_o,
  output logic signed [DW-1:0] filter_out_o,
  output logic signed [DW-1:0] error_out_o
);

  logic signed [DW-1:0]   mul_a;
  logic signed [DW-1:0]   mul_b;
  logic signed [2*DW-1:0] prod_q;
  logic signed [DW-1:0]   wold_q;
  logic signed [2*DW-1:0] acc_q;
  logic signed [2*DW-1:0] acc_sh;
  logic signed [DW-1:0]   y_d;
  logic signed [DW-1:0]   y_q;
  logic signed [DW-1:0]   e_q;
  logic signed [DW-1:0]   alpha_q;
  logic signed [DW-1:0]   incr;
  logic signed [DW+1:0]   upd_sum;

  // Shift the delay line: the newest tap takes the new sample
  assign hist_wdata_o = ctrl_i.last_b ? sample_i : hist_rdata_i;

  // Select multiplier operands
  always_comb begin
    case (ctrl_i.op_b)
      OP_UPD: begin
        mul_a = alpha_q;
        mul_b = hist_rdata_i;
      end
      OP_MU: begin
        mul_a = e_q;
        mul_b = step_size_i;
      end
      default: begin
        mul_a = hist_wdata_o;
        mul_b = w_rdata_i;
      end
    endcase
  end

  // Output: low word of the sum shifted right by 31 - output_shift
  assign acc_sh = acc_q >>> (~output_shift_i);
  assign y_d    = acc_sh[DW-1:0];

  // Weight update: old weight plus twice the high word of alpha * x
  assign incr    = prod_q[2*DW-1:DW];
  assign upd_sum = {{2{wold_q[DW-1]}}, wold_q} + {incr[DW-1], incr, 1'b0};

  always_comb begin
    if (!upd_sum[DW+1] && (upd_sum[DW:DW-1] != 2'b00)) begin
      w_wdata_o = Q31_MAX;
    end else if (upd_sum[DW+1] && (upd_sum[DW:DW-1] != 2'b11)) begin
      w_wdata_o = Q31_MIN;
    end else begin
      w_wdata_o = upd_sum[DW-1:0];
    end
  end

  // Multiply, accumulate and hold intermediate results
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    wold_q <= w_rdata_i;
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.op_c == OP_FIR) begin
      acc_q <= acc_q + prod_q;
    end
    if (ctrl_i.ye_ld) begin
      y_q <= y_d;
      e_q <= reference_i - y_d;
    end
    if (ctrl_i.op_c == OP_MU) begin
      alpha_q <= prod_q[2*DW-2:DW-1];
    end
  end

  assign filter_out_o = y_q;
  assign error_out_o  = e_q;

endmodule

`default_nettype wire

/* sv/lms_adaptive_fir_q31_unit.sv */
// ----------------------------------------------------------------------------
// LMS adaptive FIR filter, Q31
// Sequencer, delay-line and weight memories, and result register.
// ----------------------------------------------------------------------------
// A sample request is finished before the next request is accepted: one
// shared multiplier walks the active taps once for the filter sum while the
// delay line shifts in memory, once more for the weight update, and the error
// and step terms pass through it in between, each pass reading the memories
// one entry a cycle. Write, read and clear requests sweep the delay-line
// memory one entry a cycle over all TAPS_MAX entries, and a read then
// returns a response. After reset both memories are cleared before the
// first request is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module lms_adaptive_fir_q31_unit import lmsq31_pkg::*; #(
  parameter int unsigned TAPS_MAX = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lmsq31_stream_if.sink     req_i,
  lmsq31_stream_if.source   rsp_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [DW-1:0]     cfg_data_i
);

  localparam int unsigned AW = (TAPS_MAX > 1) ? $clog2(TAPS_MAX) : 1;
  localparam int unsigned NW = (AW + 1 > 6) ? AW + 1 : 6;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS_MAX - 1);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INIT    = 11'b000_0000_0010,
    S_FIR     = 11'b000_0000_0100,
    S_FIR_DRN = 11'b000_0000_1000,
    S_YE      = 11'b000_0001_0000,
    S_MU      = 11'b000_0010_0000,
    S_MU_DRN  = 11'b000_0100_0000,
    S_UPD     = 11'b000_1000_0000,
    S_UPD_DRN = 11'b001_0000_0000,
    S_CLR     = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  in_item_t      item_q;
  logic [5:0]    taps_q;
  logic [DW-1:0] mu_q;
  logic [4:0]    shift_q;

  op_e           b_op_q, c_op_q, op_a;
  logic          b_last_q;
  logic [AW-1:0] b_idx_q, c_idx_q;

  logic          out_valid_q, out_valid_d;
  out_item_t     out_q;
  logic          out_load;

  logic [NW-1:0] taps_ext;
  logic [AW-1:0] last_tap;
  logic          last_a;
  logic          pipe_empty;
  logic          accept;
  logic          tidx_ok;
  logic [AW-1:0] tidx_addr;

  logic          h_we, h_re, w_we, w_re;
  logic [AW-1:0] h_waddr, h_raddr, w_waddr, w_raddr;
  logic [DW-1:0] h_wdata, w_wdata, h_rdata, w_rdata;
  logic signed [DW-1:0] mac_hist_wdata, mac_w_wdata, mac_y, mac_e;
  mac_ctrl_t     mac_ctrl;

  // Handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Active tap count clamped to 1..TAPS_MAX, as a last index
  assign taps_ext = NW'(taps_q);
  always_comb begin
    if (taps_ext == '0) begin
      last_tap = '0;
    end else if (taps_ext > NW'(TAPS_MAX)) begin
      last_tap = LAST_ADDR;
    end else begin
      last_tap = AW'(taps_ext - NW'(1));
    end
  end

  assign last_a     = (idx_q == last_tap);
  assign pipe_empty = (b_op_q == OP_NONE) && (c_op_q == OP_NONE);
  assign tidx_ok    = (NW'(item_q.tap_index) < NW'(TAPS_MAX));
  assign tidx_addr  = AW'(item_q.tap_index);

  // Sequence the passes
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    op_a    = OP_NONE;
    case (state_q)
      S_INIT: begin
        if (idx_q == LAST_ADDR) begin
          state_d = S_IDLE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_IDLE: begin
        idx_d = '0;
        if (accept) begin
          state_d = (req_i.data.kind == KIND_SAMPLE) ? S_FIR : S_CLR;
        end
      end
      S_FIR: begin
        op_a = OP_FIR;
        if (last_a) begin
          state_d = S_FIR_DRN;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_FIR_DRN: begin
        if (pipe_empty) begin
          state_d = S_YE;
        end
      end
      S_YE: begin
        state_d = S_MU;
      end
      S_MU: begin
        op_a    = OP_MU;
        state_d = S_MU_DRN;
      end
      S_MU_DRN: begin
        if (pipe_empty) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        op_a = OP_UPD;
        if (last_a) begin
          state_d = S_UPD_DRN;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_UPD_DRN: begin
        if (pipe_empty) begin
          state_d = S_DONE;
        end
      end
      S_CLR: begin
        if (idx_q == LAST_ADDR) begin
          state_d = (item_q.kind == KIND_READ) ? S_DONE : S_IDLE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      idx_q    <= '0;
      b_op_q   <= OP_NONE;
      c_op_q   <= OP_NONE;
      b_last_q <= 1'b0;
      b_idx_q  <= '0;
      c_idx_q  <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      b_op_q   <= op_a;
      c_op_q   <= b_op_q;
      b_last_q <= last_a;
      b_idx_q  <= idx_q;
      c_idx_q  <= b_idx_q;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i.data;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q  <= TAPS_RST;
      mu_q    <= MU_RST;
      shift_q <= SHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TAPS:  taps_q  <= cfg_data_i[5:0];
        CFG_MU:    mu_q    <= cfg_data_i;
        CFG_SHIFT: shift_q <= cfg_data_i[4:0];
        default:   ;
      endcase
    end
  end

  // Delay-line memory ports
  always_comb begin
    h_re    = (state_q == S_FIR) || (state_q == S_UPD);
    h_raddr = ((state_q == S_FIR) && !last_a) ? idx_q + AW'(1) : idx_q;
    if ((state_q == S_INIT) || (state_q == S_CLR)) begin
      h_we    = 1'b1;
      h_waddr = idx_q;
      h_wdata = '0;
    end else begin
      h_we    = (b_op_q == OP_FIR);
      h_waddr = b_idx_q;
      h_wdata = mac_hist_wdata;
    end
  end

  // Weight memory ports
  always_comb begin
    w_re    = (state_q == S_FIR) || (state_q == S_UPD) ||
              ((state_q == S_CLR) && (idx_q == '0));
    w_raddr = (state_q == S_CLR) ? tidx_addr : idx_q;
    if (state_q == S_INIT) begin
      w_we    = 1'b1;
      w_waddr = idx_q;
      w_wdata = '0;
    end else if (state_q == S_CLR) begin
      w_we    = (idx_q == '0) && (item_q.kind == KIND_WRITE) && tidx_ok;
      w_waddr = tidx_addr;
      w_wdata = item_q.tap_value;
    end else begin
      w_we    = (c_op_q == OP_UPD);
      w_waddr = c_idx_q;
      w_wdata = mac_w_wdata;
    end
  end

  lmsq31_ram #(.W(DW), .D(TAPS_MAX)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  lmsq31_ram #(.W(DW), .D(TAPS_MAX)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // Arithmetic unit controls
  always_comb begin
    mac_ctrl.op_b    = b_op_q;
    mac_ctrl.op_c    = c_op_q;
    mac_ctrl.last_b  = b_last_q;
    mac_ctrl.acc_clr = (state_q == S_IDLE);
    mac_ctrl.ye_ld   = (state_q == S_YE);
  end

  lmsq31_mac u_mac (
    .clk_i          (clk_i),
    .ctrl_i         (mac_ctrl),
    .hist_rdata_i   (h_rdata),
    .w_rdata_i      (w_rdata),
    .sample_i       (item_q.sample),
    .reference_i    (item_q.reference),
    .step_size_i    (mu_q),
    .output_shift_i (shift_q),
    .hist_wdata_o   (mac_hist_wdata),
    .w_wdata_o      (mac_w_wdata),
    .filter_out_o   (mac_y),
    .error_out_o    (mac_e)
  );

  // Result register: load when empty or being drained
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);
  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (item_q.kind == KIND_READ) begin
        out_q.filter_out <= '0;
        out_q.error_out  <= '0;
        out_q.tap_read   <= tidx_ok ? w_rdata : '0;
        out_q.is_read    <= 1'b1;
      end else begin
        out_q.filter_out <= mac_y;
        out_q.error_out  <= mac_e;
        out_q.tap_read   <= '0;
        out_q.is_read    <= 1'b0;
      end
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Checks
  a_accept_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> pipe_empty)
    else $error("request accepted with multiply pipeline busy");

  a_ye_acc_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_YE) |-> (c_op_q == OP_NONE) && (b_op_q == OP_NONE))
    else $error("output formed before accumulation finished");

  a_clr_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_we && (state_q == S_CLR)) |-> (idx_q == '0) && (item_q.kind == KIND_WRITE))
    else $error("weight written during clear sweep outside the write slot");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("response raised outside the done state");

endmodule

`default_nettype wire
